// ===== design/tbp_pkg.sv =====
package tbp_pkg;

	localparam int MAX_BITS_DEF = 64;
	localparam int DATA_W = 64;
	localparam int LEN_W = 7;
	localparam int ENT_W = 6;
	localparam int GRP_W = 8;

	typedef enum logic [1:0] {
		FUNC_LOAD,
		FUNC_FWD,
		FUNC_INV,
		FUNC_SCT
	} func_t;

	typedef enum logic [1:0] {
		TSEL_FWD,
		TSEL_EXACT,
		TSEL_PSEUDO
	} tsel_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_LEN,
		STAT_IDX
	} status_t;

	typedef enum logic [1:0] {
		CFG_INPUT_SIZE,
		CFG_OUTPUT_SIZE,
		CFG_HAS_EXACT,
		CFG_HAS_PSEUDO
	} cfg_idx_t;

	typedef struct packed {
		logic             en;
		logic [1:0]       sel;
		logic [ENT_W-1:0] idx;
		logic [ENT_W-1:0] val;
	} tbl_wr_t;

endpackage

// ===== design/tbp_if.sv =====
interface tbp_cmd_if;
	import tbp_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        func;
	logic [1:0]        table_select;
	logic [ENT_W-1:0]  entry_index;
	logic [ENT_W-1:0]  entry_value;
	logic [DATA_W-1:0] data_bits;
	logic [LEN_W-1:0]  data_length;

	modport source (
		output valid, func, table_select, entry_index, entry_value, data_bits, data_length,
		input  ready
	);
	modport sink (
		input  valid, func, table_select, entry_index, entry_value, data_bits, data_length,
		output ready
	);
endinterface

interface tbp_rsp_if;
	import tbp_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] result_bits;
	logic [LEN_W-1:0]  result_length;
	logic [1:0]        status;

	modport source (
		output valid, result_bits, result_length, status,
		input  ready
	);
	modport sink (
		input  valid, result_bits, result_length, status,
		output ready
	);
endinterface

// ===== design/tbp_tables.sv =====
module tbp_tables #(
	parameter int MAX_BITS = tbp_pkg::MAX_BITS_DEF
) (
	input  logic                       clk,
	input  tbp_pkg::tbl_wr_t           wr,
	input  tbp_pkg::tsel_t             rd_sel,
	output logic [tbp_pkg::ENT_W-1:0]  entry [MAX_BITS]
);
	import tbp_pkg::*;

	localparam int IDX_W = $clog2(MAX_BITS);

	logic [ENT_W-1:0] fwd_q    [MAX_BITS];
	logic [ENT_W-1:0] exact_q  [MAX_BITS];
	logic [ENT_W-1:0] pseudo_q [MAX_BITS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			unique case (wr.sel)
				TSEL_FWD:    fwd_q[wr.idx[IDX_W-1:0]] <= wr.val;
				TSEL_EXACT:  exact_q[wr.idx[IDX_W-1:0]] <= wr.val;
				TSEL_PSEUDO: pseudo_q[wr.idx[IDX_W-1:0]] <= wr.val;
				default: ;
			endcase
		end
	end

	// Every entry is read at its own position; the mode picks the table.
	always_comb begin
		for (int i = 0; i < MAX_BITS; i++) begin
			unique case (rd_sel)
				TSEL_EXACT:  entry[i] = exact_q[i];
				TSEL_PSEUDO: entry[i] = pseudo_q[i];
				default:     entry[i] = fwd_q[i];
			endcase
		end
	end

endmodule

// ===== design/table_bit_permuter_top.sv =====
// Programmable bit permutation box.
// Items arrive on the cmd channel and results leave on the rsp channel, both
// valid/ready; a transfer happens at a clock edge with valid and ready high.
// A load item writes one entry of the forward, exact inverse or pseudo inverse
// table and returns an empty result. Data items are gathered through a table,
// or scattered through the forward table, and return one result each.
// Each item moves through the four pipeline registers in order; the last,
// the output register, drives rsp valid and holds the result. One item is
// taken every cycle while the receiver does not stall. A loaded entry is
// seen by the very next item.
// The user must write the configuration registers through cfg_we/cfg_index/
// cfg_data only while no item is in flight; the block does not enforce this.
// Reset empties the pipeline and sets both sizes to 64 and both inverse flags
// to zero; table entries stay undefined until loaded.
// When the receiver stalls, the result is held and the stages behind it fill
// up; cmd ready drops only once all four stages hold items.
module table_bit_permuter_top #(
	parameter int MAX_BITS = tbp_pkg::MAX_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	tbp_cmd_if.sink                    cmd,
	tbp_rsp_if.source                  rsp,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [tbp_pkg::LEN_W-1:0]  cfg_data
);
	import tbp_pkg::*;

	localparam int NGRP = (MAX_BITS + GRP_W - 1) / GRP_W;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BITS);

	// Configuration registers.
	logic [LEN_W-1:0] input_size_q;
	logic [LEN_W-1:0] output_size_q;
	logic             has_exact_q;
	logic             has_pseudo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_size_q  <= LEN_W'(64);
			output_size_q <= LEN_W'(64);
			has_exact_q   <= 1'b0;
			has_pseudo_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_INPUT_SIZE:  input_size_q  <= cfg_data;
				CFG_OUTPUT_SIZE: output_size_q <= cfg_data;
				CFG_HAS_EXACT:   has_exact_q   <= cfg_data[0];
				CFG_HAS_PSEUDO:  has_pseudo_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage handshake.
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4      = !v_s4 || rsp.ready;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign cmd.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= cmd.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Table store, written at the transfer of a load item.
	tbl_wr_t          tbl_wr;
	tsel_t            rd_sel;
	logic [ENT_W-1:0] entry [MAX_BITS];

	always_comb begin
		tbl_wr.en  = cmd.valid && rdy1 && (cmd.func == FUNC_LOAD)
			&& (LEN_W'(cmd.entry_index) < MAX_LEN);
		tbl_wr.sel = cmd.table_select;
		tbl_wr.idx = cmd.entry_index;
		tbl_wr.val = cmd.entry_value;
	end

	tbp_tables #(
		.MAX_BITS (MAX_BITS)
	) u_tables (
		.clk    (clk),
		.wr     (tbl_wr),
		.rd_sel (rd_sel),
		.entry  (entry)
	);

	// Stage 1: registered item.
	logic [1:0]        func_s1;
	logic [DATA_W-1:0] data_s1;
	logic [LEN_W-1:0]  dlen_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && cmd.valid) begin
			func_s1 <= cmd.func;
			data_s1 <= cmd.data_bits;
			dlen_s1 <= cmd.data_length;
		end
	end

	// Stage 1 decode: lengths, mismatch, table entries and active positions.
	logic              is_load, is_fwd, is_inv, is_sct;
	logic [LEN_W-1:0]  dlen, isz, osz, n_act, lim, rlen;
	logic              mism, zero_res;
	logic [DATA_W-1:0] data_m;
	logic [MAX_BITS-1:0] act;

	always_comb begin
		is_load = (func_s1 == FUNC_LOAD);
		is_fwd  = (func_s1 == FUNC_FWD);
		is_inv  = (func_s1 == FUNC_INV);
		is_sct  = (func_s1 == FUNC_SCT);
		dlen = (dlen_s1 > MAX_LEN) ? MAX_LEN : dlen_s1;
		isz  = (input_size_q > MAX_LEN) ? MAX_LEN : input_size_q;
		osz  = (output_size_q > MAX_LEN) ? MAX_LEN : output_size_q;
		mism = is_fwd ? (dlen != isz) : (!is_load && (dlen != osz));
		n_act = is_inv ? isz : osz;
		lim   = is_sct ? isz : dlen;
		// Inverse with neither flag set gives an all-zero string.
		zero_res = is_load || mism || (is_inv && !has_exact_q && !has_pseudo_q);
		if (is_load || mism) rlen = '0;
		else if (is_fwd)     rlen = osz;
		else                 rlen = isz;
		if (is_inv) rd_sel = has_exact_q ? TSEL_EXACT : TSEL_PSEUDO;
		else        rd_sel = TSEL_FWD;
		for (int i = 0; i < DATA_W; i++) begin
			data_m[i] = data_s1[i] && (LEN_W'(i) < dlen);
		end
		for (int i = 0; i < MAX_BITS; i++) begin
			act[i] = LEN_W'(i) < n_act;
		end
	end

	// Stage 2.
	logic [ENT_W-1:0]    ent_s2 [MAX_BITS];
	logic [MAX_BITS-1:0] act_s2;
	logic [DATA_W-1:0]   data_s2;
	logic [LEN_W-1:0]    lim_s2, rlen_s2;
	logic                mism_s2, zero_s2, sct_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			ent_s2  <= entry;
			act_s2  <= act;
			data_s2 <= data_m;
			lim_s2  <= lim;
			rlen_s2 <= rlen;
			mism_s2 <= mism;
			zero_s2 <= zero_res;
			sct_s2  <= is_sct;
		end
	end

	// Stage 2 work: index checks, gather muxes and partial scatter sums.
	logic [MAX_BITS-1:0] bad_vec;
	logic                bad;
	logic [DATA_W-1:0]   gath;
	logic [DATA_W-1:0]   part [NGRP];

	always_comb begin
		gath = '0;
		for (int i = 0; i < MAX_BITS; i++) begin
			bad_vec[i] = act_s2[i] && (LEN_W'(ent_s2[i]) >= lim_s2);
			gath[i]    = data_s2[ent_s2[i]];
		end
		bad = !zero_s2 && (|bad_vec);
		for (int k = 0; k < NGRP; k++) begin
			part[k] = '0;
			for (int b = 0; b < GRP_W; b++) begin
				if (k * GRP_W + b < MAX_BITS) begin
					if (data_s2[k * GRP_W + b]) begin
						part[k] = part[k] | (DATA_W'(1) << ent_s2[k * GRP_W + b]);
					end
				end
			end
		end
	end

	// Stage 3.
	logic [DATA_W-1:0] gath_s3;
	logic [DATA_W-1:0] part_s3 [NGRP];
	logic [LEN_W-1:0]  rlen_s3;
	logic              bad_s3, mism_s3, zero_s3, sct_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			gath_s3 <= gath;
			part_s3 <= part;
			rlen_s3 <= rlen_s2;
			bad_s3  <= bad;
			mism_s3 <= mism_s2;
			zero_s3 <= zero_s2;
			sct_s3  <= sct_s2;
		end
	end

	// Stage 3 work: finish the scatter, apply status and length mask.
	logic [DATA_W-1:0] sct_res, res, res_m;
	logic [LEN_W-1:0]  rlen_f;
	status_t           stat_f;

	always_comb begin
		sct_res = '0;
		for (int k = 0; k < NGRP; k++) begin
			sct_res = sct_res | part_s3[k];
		end
		if (mism_s3)     stat_f = STAT_LEN;
		else if (bad_s3) stat_f = STAT_IDX;
		else             stat_f = STAT_OK;
		if (zero_s3 || bad_s3) res = '0;
		else if (sct_s3)       res = sct_res;
		else                   res = gath_s3;
		rlen_f = bad_s3 ? '0 : rlen_s3;
		for (int i = 0; i < DATA_W; i++) begin
			res_m[i] = res[i] && (LEN_W'(i) < rlen_f);
		end
	end

	// Stage 4: output register.
	logic [DATA_W-1:0] res_s4;
	logic [LEN_W-1:0]  rlen_s4;
	status_t           stat_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			res_s4  <= res_m;
			rlen_s4 <= rlen_f;
			stat_s4 <= stat_f;
		end
	end

	assign rsp.valid         = v_s4;
	assign rsp.result_bits   = res_s4;
	assign rsp.result_length = rlen_s4;
	assign rsp.status        = stat_s4;

endmodule
